// File: rtl/lbfr_pkg.sv
// ----------------------------------------------------------------------------
// lbfr_pkg
// Shared constants and types for the streaming literal find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package lbfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int REG_BYTES = 16;                 // bytes held by a pattern/replacement pair
    localparam int REG_W     = 64;                 // width of one byte-bank register
    localparam int LEN_W     = 5;                  // length registers and window fill
    localparam int IDX_W     = $clog2(REG_BYTES);  // byte index within a register pair
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_PATTERN    = 16;
    localparam int DEF_MAX_SUBSTITUTE = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSTITUTE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSTITUTE_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSTITUTE_LENGTH = 3'd5;

    typedef logic [BYTE_W-1:0] byte_t;

    // Per-cell control for one transfer
    typedef struct packed {
        logic at_tail;   // this cell is the slot the incoming byte lands in
        logic wr_en;     // store the incoming byte at the tail slot
        logic sh_en;     // drop the oldest byte: take the neighbor's byte
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/lbfr_cell.sv
// ----------------------------------------------------------------------------
// lbfr_cell
// One window slot: holds a byte, compares it against its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfr_cell (
    input  wire                    aclk,
    input  lbfr_pkg::byte_t        in_byte,
    input  lbfr_pkg::byte_t        pat_byte,
    input  lbfr_pkg::byte_t        next_eff,   // effective byte of the younger neighbor
    input  lbfr_pkg::cell_ctl_t    ctl,
    output lbfr_pkg::byte_t        eff,        // slot contents as seen by this transfer
    output logic                   eq,
    output lbfr_pkg::byte_t        held
);
    import lbfr_pkg::*;

    byte_t win_reg;

    assign eff  = ctl.at_tail ? in_byte : win_reg;
    assign eq   = (eff == pat_byte);
    assign held = win_reg;

    always_ff @(posedge aclk) begin
        if (ctl.sh_en) begin
            win_reg <= next_eff;
        end else if (ctl.wr_en && ctl.at_tail) begin
            win_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lbfr_outq.sv
// ----------------------------------------------------------------------------
// lbfr_outq
// Two-entry result queue in front of the master-side stream port.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfr_outq (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  lbfr_pkg::byte_t    push_byte,
    input  wire                push_last,
    output logic               room,
    output logic               m_tvalid,
    input  wire                m_tready,
    output lbfr_pkg::byte_t    m_tdata,
    output logic               m_tlast
);
    import lbfr_pkg::*;

    byte_t      data_reg [2];
    logic       last_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign room     = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = data_reg[rd_ptr_reg];
    assign m_tlast  = last_reg[rd_ptr_reg];

    assign do_push = push && room;
    assign do_pop  = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_reg[wr_ptr_reg] <= push_byte;
            last_reg[wr_ptr_reg] <= push_last;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/literal_byte_find_replace.sv
// ----------------------------------------------------------------------------
// literal_byte_find_replace
// Streaming literal find-and-replace over a byte stream.
// ----------------------------------------------------------------------------
// An input transfer loads the result emitter register, whose result then goes
// into the result queue; m_tvalid rises once the queue holds it. Throughput,
// while the queue has room: 1 byte per cycle for bytes that give at most one
// result. A replacement or final flush of n bytes is sent by the single result
// emitter at that rate, so s_tready stays low until its last byte is pushed.
// Reset (aresetn low, synchronous): all configuration registers read zero
// (pass-through), window empty, result queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module literal_byte_find_replace #(
    parameter int MAX_PATTERN    = lbfr_pkg::DEF_MAX_PATTERN,
    parameter int MAX_SUBSTITUTE = lbfr_pkg::DEF_MAX_SUBSTITUTE
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // input stream
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  lbfr_pkg::byte_t                 s_tdata,   // [7:0] in_byte
    input  wire                             s_tlast,   // in_final
    // result stream
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output lbfr_pkg::byte_t                 m_tdata,   // [7:0] out_byte
    output logic                            m_tlast,   // out_final
    // configuration writes
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [lbfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [lbfr_pkg::REG_W-1:0]       cfg_data
);
    import lbfr_pkg::*;

    // Lengths saturate at the register capacity and at the build limits.
    localparam int PCAP  = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int SCAP  = (MAX_SUBSTITUTE < REG_BYTES) ? MAX_SUBSTITUTE : REG_BYTES;
    localparam int NCELL = PCAP;
    localparam int IW    = (NCELL > 1) ? $clog2(NCELL) : 1;

    typedef enum logic [1:0] {
        EM_SINGLE,
        EM_SUB,
        EM_WIN
    } em_kind_t;

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0] pat_low_reg, pat_high_reg, sub_low_reg, sub_high_reg;
    logic [LEN_W-1:0] pat_len_reg, sub_len_reg;
    logic             cfg_fire;
    logic             cfg_len_wr;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_len_wr = cfg_fire && ((cfg_index == REG_PATTERN_LENGTH) ||
                                     (cfg_index == REG_SUBSTITUTE_LENGTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            sub_low_reg  <= '0;
            sub_high_reg <= '0;
            sub_len_reg  <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_PATTERN_LOW:       pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH:      pat_high_reg <= cfg_data;
                REG_PATTERN_LENGTH:    pat_len_reg  <= cfg_data[LEN_W-1:0];
                REG_SUBSTITUTE_LOW:    sub_low_reg  <= cfg_data;
                REG_SUBSTITUTE_HIGH:   sub_high_reg <= cfg_data;
                REG_SUBSTITUTE_LENGTH: sub_len_reg  <= cfg_data[LEN_W-1:0];
                default: ;             // index beyond the register list: drop
            endcase
        end
    end

    logic [2*REG_W-1:0] pat_bytes, sub_bytes;
    logic [LEN_W-1:0]   plen, slen;
    logic               pass;

    assign pat_bytes = {pat_high_reg, pat_low_reg};
    assign sub_bytes = {sub_high_reg, sub_low_reg};
    assign plen = (pat_len_reg > LEN_W'(PCAP)) ? LEN_W'(PCAP) : pat_len_reg;
    assign slen = (sub_len_reg > LEN_W'(SCAP)) ? LEN_W'(SCAP) : sub_len_reg;
    // Empty pattern or empty replacement: stream goes through untouched.
    assign pass = (plen == '0) || (slen == '0);

    // ---------------- window: row of cells, oldest byte in cell 0 ----------------
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0] fill_inc, tail;
    logic             s_fire;
    logic             full, match;
    logic             do_shift, do_write;

    byte_t      eff_a  [NCELL];
    byte_t      held_a [NCELL];
    logic [NCELL-1:0] eq_vec, use_vec;
    cell_ctl_t  ctl_a  [NCELL];

    assign s_fire   = s_tvalid && s_tready;
    // Window length after this byte lands; restart if it somehow overran.
    assign fill_inc = (fill_reg >= plen) ? LEN_W'(1) : fill_reg + LEN_W'(1);
    assign tail     = fill_inc - LEN_W'(1);
    assign full     = (fill_inc == plen);
    assign match    = full && (&(eq_vec | ~use_vec));

    // Full window without a match and more to come: send the oldest, shift.
    assign do_shift = s_fire && !pass && full && !match && !s_tlast;
    // Otherwise, outside pass-through and matches, the byte is stored at the tail (flush reads it back).
    assign do_write = s_fire && !pass && !match && !(full && !s_tlast);

    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        assign use_vec[j]       = (LEN_W'(j) < plen);
        assign ctl_a[j].at_tail = (tail == LEN_W'(j));
        assign ctl_a[j].wr_en   = do_write;
        assign ctl_a[j].sh_en   = do_shift;

        lbfr_cell u_cell (
            .aclk     (aclk),
            .in_byte  (s_tdata),
            .pat_byte (pat_bytes[BYTE_W*j +: BYTE_W]),
            .next_eff (eff_a[(j + 1 < NCELL) ? j + 1 : j]),
            .ctl      (ctl_a[j]),
            .eff      (eff_a[j]),
            .eq       (eq_vec[j]),
            .held     (held_a[j])
        );
    end

    always_comb begin
        fill_next = fill_reg;
        if (cfg_len_wr) begin
            fill_next = '0;                    // length change: drop held bytes
        end else if (s_fire) begin
            if (pass || match || s_tlast) begin
                fill_next = '0;
            end else if (full) begin
                fill_next = plen - LEN_W'(1);
            end else begin
                fill_next = fill_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // ---------------- result emitter ----------------
    // Holds one job: a single byte, the replacement, or a window flush,
    // and pushes one result per cycle into the output queue while it has room.
    logic             em_valid_reg;
    em_kind_t         em_kind_reg;
    byte_t            em_byte_reg;
    logic [IDX_W-1:0] em_idx_reg, em_last_reg;
    logic             em_fin_reg;
    logic             em_end, push, q_room;
    byte_t            em_out;

    assign em_end   = (em_idx_reg == em_last_reg);
    assign push     = em_valid_reg && q_room;
    // Take a new byte when the emitter is free or hands over its last result now.
    assign s_tready = !em_valid_reg || (em_end && q_room);

    always_comb begin
        case (em_kind_reg)
            EM_SINGLE: em_out = em_byte_reg;
            EM_SUB:    em_out = sub_bytes[{em_idx_reg, 3'b000} +: BYTE_W];
            EM_WIN:    em_out = held_a[em_idx_reg[IW-1:0]];
            default:   em_out = em_byte_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
        end else if (s_fire) begin
            // a new transfer lands only when the previous job is done or ends now
            em_idx_reg   <= '0;
            em_valid_reg <= pass || match || s_tlast || full;
            if (pass) begin
                em_kind_reg  <= EM_SINGLE;
                em_byte_reg  <= s_tdata;
                em_last_reg  <= '0;
                em_fin_reg   <= s_tlast;
            end else if (match) begin
                em_kind_reg  <= EM_SUB;
                em_last_reg  <= slen[IDX_W-1:0] - IDX_W'(1);
                em_fin_reg   <= s_tlast;
            end else if (s_tlast) begin
                // flush everything held, the new byte included
                em_kind_reg  <= EM_WIN;
                em_last_reg  <= tail[IDX_W-1:0];
                em_fin_reg   <= 1'b1;
            end else if (full) begin
                em_kind_reg  <= EM_SINGLE;
                em_byte_reg  <= eff_a[0];
                em_last_reg  <= '0;
                em_fin_reg   <= 1'b0;
            end
        end else if (push) begin
            if (em_end) begin
                em_valid_reg <= 1'b0;
            end else begin
                em_idx_reg <= em_idx_reg + IDX_W'(1);
            end
        end
    end

    // ---------------- output queue ----------------
    lbfr_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_byte (em_out),
        .push_last (em_fin_reg && em_end),
        .room      (q_room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
